// ----- rtl/btnkc_pkg.sv -----
// Shared types and codes for the B-tree internal node table.
// No dependencies; imported by the core, the compare unit and the checker.
`default_nettype none

package btnkc_pkg;

    localparam int KEY_W  = 64;
    localparam int PAGE_W = 31;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    // outcome of the shared compare unit
    typedef struct packed {
        logic key_lt;   // lhs key < rhs key
        logic page_eq;  // page operands equal
    } cmp_res_t;

endpackage

`default_nettype wire

// ----- rtl/btree_node_key_child_table_core.sv -----
// B-tree internal node: sorted key table and child pages, sequencer on top.
// Depends on btnkc_pkg, btnkc_ram, btnkc_cmp.
//
//  channel | dir | handshake            | word
//  --------+-----+----------------------+----------------------------------------------
//  req     | in  | req_valid/req_ready  | func, key, left_child, right_child, victim_page
//  rsp     | out | rsp_valid/rsp_ready  | status, child_page, count_after
//
// The block handles one word at a time. Insert shifts every key above the
// insert position up one slot, search scans keys upward to the first key above
// the probe (or to the end), remove scans the children for the victim and shifts the rest down.
// The single read and write port of each store sets the pace: one entry moves
// or is compared per cycle. A full node on insert, an empty node on search or
// remove, and an unused func skip the stores and go straight to the result.
// Reset empties the node (count to zero); stores are not cleared.
// req_ready is high whenever the sequencer is idle, even while a result
// waits in the output register; a stalled rsp only holds the next result.
`default_nettype none

module btree_node_key_child_table_core
    import btnkc_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  req_valid,
    output logic                                       req_ready,
    input  wire logic [FUNC_W-1:0]                     func,
    input  wire logic [KEY_W-1:0]                      key,
    input  wire logic [PAGE_W-1:0]                     left_child,
    input  wire logic [PAGE_W-1:0]                     right_child,
    input  wire logic [PAGE_W-1:0]                     victim_page,
    output logic                                       rsp_valid,
    input  wire logic                                  rsp_ready,
    output logic [STAT_W-1:0]                          status,
    output logic [PAGE_W-1:0]                          child_page,
    output logic [$clog2(MAX_KEYS+1)-1:0]              count_after
);

    localparam int CW  = $clog2(MAX_KEYS + 1);               // count / child index
    localparam int EW  = CW + 1;                             // index plus lookahead
    localparam int KAW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INS_E   = 4'd1;   // empty node: store left child
    localparam logic [3:0] S_INS_RD  = 4'd2;   // prime read of top entry
    localparam logic [3:0] S_INS_SH  = 4'd3;   // compare and shift up, top down
    localparam logic [3:0] S_INS_PUT = 4'd4;   // place new key at slot 0
    localparam logic [3:0] S_SR_RD   = 4'd5;
    localparam logic [3:0] S_SR_SC   = 4'd6;   // scan keys upward
    localparam logic [3:0] S_SR_LAST = 4'd7;   // last child comes back
    localparam logic [3:0] S_RM_RD   = 4'd8;
    localparam logic [3:0] S_RM_SC   = 4'd9;   // scan children for victim
    localparam logic [3:0] S_RM_SH   = 4'd10;  // shift down over the hole
    localparam logic [3:0] S_DONE    = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     idx_reg, idx_next;

    // latched request word
    logic [KEY_W-1:0]  key_reg;
    logic [PAGE_W-1:0] left_reg, right_reg, victim_reg;

    // pending result
    logic [STAT_W-1:0] res_status_reg, res_status_next;
    logic [PAGE_W-1:0] res_page_reg, res_page_next;

    // output register
    logic              rsp_valid_reg, rsp_valid_next;
    logic [STAT_W-1:0] rsp_status_reg;
    logic [PAGE_W-1:0] rsp_page_reg;
    logic [CW-1:0]     rsp_count_reg;
    logic              rsp_load;

    // store ports
    logic              key_we, child_we;
    logic [KAW-1:0]    key_waddr, key_raddr;
    logic [CW-1:0]     child_waddr, child_raddr;
    logic [KEY_W-1:0]  key_wdata, key_rd;
    logic [PAGE_W-1:0] child_wdata, child_rd;

    // compare unit
    logic [KEY_W-1:0]  cmp_lhs, cmp_rhs;
    cmp_res_t          cmp;

    logic              req_fire;
    logic [EW-1:0]     idx_p1, idx_p2, idx_m1, idx_m2, cnt_m1;

    // keep lookahead reads inside the stores; those reads are discarded anyway
    function automatic logic [KAW-1:0] kaddr(input logic [EW-1:0] v);
        logic [KAW-1:0] a;
        a = '0;
        if (v < EW'(MAX_KEYS))
        begin
            a = v[KAW-1:0];
        end
        return a;
    endfunction

    function automatic logic [CW-1:0] caddr(input logic [EW-1:0] v);
        logic [CW-1:0] a;
        a = '0;
        if (v < EW'(MAX_KEYS + 1))
        begin
            a = v[CW-1:0];
        end
        return a;
    endfunction

    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;

    assign idx_p1 = EW'(idx_reg) + EW'(1);
    assign idx_p2 = EW'(idx_reg) + EW'(2);
    assign idx_m1 = EW'(idx_reg) - EW'(1);
    assign idx_m2 = EW'(idx_reg) - EW'(2);
    assign cnt_m1 = EW'(cnt_reg) - EW'(1);

    // insert asks "stored < new", search asks "probe < stored"
    assign cmp_lhs = (state_reg == S_INS_SH) ? key_rd  : key_reg;
    assign cmp_rhs = (state_reg == S_INS_SH) ? key_reg : key_rd;

    btnkc_cmp u_cmp (
        .lhs_key  (cmp_lhs),
        .rhs_key  (cmp_rhs),
        .lhs_page (child_rd),
        .rhs_page (victim_reg),
        .res      (cmp)
    );

    btnkc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_KEYS),
        .AW    (KAW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rd)
    );

    btnkc_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_KEYS + 1),
        .AW    (CW)
    ) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .raddr (child_raddr),
        .rdata (child_rd)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        key_we          = 1'b0;
        key_waddr       = idx_reg[KAW-1:0];
        key_wdata       = key_rd;
        key_raddr       = '0;
        child_we        = 1'b0;
        child_waddr     = caddr(idx_p1);
        child_wdata     = child_rd;
        child_raddr     = '0;
        rsp_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_page_next   = '0;
                    state_next      = S_DONE;
                    priority if (func == FN_INSERT)
                    begin
                        if (cnt_reg == CW'(MAX_KEYS))
                        begin
                            res_status_next = ST_NO_SPACE;
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_next = S_INS_E;
                        end
                        else
                        begin
                            state_next = S_INS_RD;
                        end
                    end
                    else if (func == FN_SEARCH)
                    begin
                        if (cnt_reg != '0)
                        begin
                            state_next = S_SR_RD;
                        end
                    end
                    else if (func == FN_REMOVE)
                    begin
                        if (cnt_reg != '0)
                        begin
                            state_next = S_RM_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;   // unused code: no change
                    end
                end
            end

            S_INS_E:
            begin
                child_we    = 1'b1;
                child_waddr = '0;
                child_wdata = left_reg;
                idx_next    = '0;
                state_next  = S_INS_PUT;
            end

            S_INS_RD:
            begin
                key_raddr   = kaddr(cnt_m1);
                child_raddr = cnt_reg;
                idx_next    = cnt_reg;
                state_next  = S_INS_SH;
            end

            S_INS_SH:
            begin
                // data of key[idx-1] and child[idx] is on the read ports
                key_we   = 1'b1;
                child_we = 1'b1;
                if (!cmp.key_lt)
                begin
                    // stored key >= new key: move it up one slot
                    key_raddr   = kaddr(idx_m2);
                    child_raddr = caddr(idx_m1);
                    if (idx_reg == CW'(1))
                    begin
                        state_next = S_INS_PUT;
                    end
                    idx_next = idx_m1[CW-1:0];
                end
                else
                begin
                    key_wdata       = key_reg;
                    child_wdata     = right_reg;
                    cnt_next        = cnt_reg + CW'(1);
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
            end

            S_INS_PUT:
            begin
                key_we          = 1'b1;
                key_wdata       = key_reg;
                child_we        = 1'b1;
                child_wdata     = right_reg;
                cnt_next        = cnt_reg + CW'(1);
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end

            S_SR_RD:
            begin
                idx_next   = '0;
                state_next = S_SR_SC;
            end

            S_SR_SC:
            begin
                key_raddr   = kaddr(idx_p1);
                child_raddr = caddr(idx_p1);
                if (cmp.key_lt)
                begin
                    res_page_next   = child_rd;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    if (idx_p1 == EW'(cnt_reg))
                    begin
                        state_next = S_SR_LAST;
                    end
                    idx_next = idx_p1[CW-1:0];
                end
            end

            S_SR_LAST:
            begin
                res_page_next   = child_rd;
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end

            S_RM_RD:
            begin
                idx_next   = '0;
                state_next = S_RM_SC;
            end

            S_RM_SC:
            begin
                key_raddr   = kaddr(idx_p1);
                child_raddr = caddr(idx_p1);
                if (cmp.page_eq)
                begin
                    if (idx_reg == cnt_reg)
                    begin
                        // last child goes with the last key
                        cnt_next        = cnt_m1[CW-1:0];
                        res_status_next = ST_OK;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RM_SH;
                    end
                end
                else if (idx_reg == cnt_reg)
                begin
                    state_next = S_DONE;   // no match, status already not found
                end
                else
                begin
                    idx_next = idx_p1[CW-1:0];
                end
            end

            S_RM_SH:
            begin
                // key[idx+1] and child[idx+1] slide down into slot idx
                key_raddr   = kaddr(idx_p2);
                child_raddr = caddr(idx_p2);
                child_we    = 1'b1;
                child_waddr = idx_reg;
                key_we      = (idx_p1 < EW'(cnt_reg));
                if (idx_p1 == EW'(cnt_reg))
                begin
                    cnt_next        = cnt_m1[CW-1:0];
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = idx_p1[CW-1:0];
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            key_reg    <= key;
            left_reg   <= left_child;
            right_reg  <= right_child;
            victim_reg <= victim_page;
        end
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        if (rsp_load)
        begin
            rsp_status_reg <= res_status_reg;
            rsp_page_reg   <= res_page_reg;
            rsp_count_reg  <= cnt_reg;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_status_reg;
    assign child_page  = rsp_page_reg;
    assign count_after = rsp_count_reg;

endmodule

`default_nettype wire

// ----- rtl/btnkc_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module btnkc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/btnkc_cmp.sv -----
// Shared compare unit: 64-bit unsigned less-than and page equality.
// Depends on btnkc_pkg.
`default_nettype none

module btnkc_cmp
    import btnkc_pkg::*;
(
    input  wire logic [KEY_W-1:0]  lhs_key,
    input  wire logic [KEY_W-1:0]  rhs_key,
    input  wire logic [PAGE_W-1:0] lhs_page,
    input  wire logic [PAGE_W-1:0] rhs_page,
    output cmp_res_t               res
);

    always_comb
    begin
        res.key_lt  = (lhs_key < rhs_key);
        res.page_eq = (lhs_page == rhs_page);
    end

endmodule

`default_nettype wire

// ----- rtl/btnkc_chk.sv -----
// Port-level checker for the B-tree node table, bound to the top level.
// Depends on btnkc_pkg and btree_node_key_child_table_core.
`default_nettype none

module btnkc_chk
    import btnkc_pkg::*;
#(
    parameter int MAX_KEYS = 64
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_ready,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [STAT_W-1:0]                 status,
    input wire logic [PAGE_W-1:0]                 child_page,
    input wire logic [$clog2(MAX_KEYS+1)-1:0]     count_after
);

    localparam int CW = $clog2(MAX_KEYS + 1);

    // a stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(child_page) && $stable(count_after))
        else $error("rsp word changed while stalled");

    // block is busy the cycle after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req_ready high right after accept");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> count_after <= CW'(MAX_KEYS))
        else $error("count above capacity");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_NO_SPACE |-> count_after == CW'(MAX_KEYS))
        else $error("no space reported on a node that is not full");

    a_page_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && child_page != '0 |-> status == ST_OK)
        else $error("child page returned with a failing status");

endmodule

bind btree_node_key_child_table_core btnkc_chk #(
    .MAX_KEYS (MAX_KEYS)
) u_btnkc_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .child_page  (child_page),
    .count_after (count_after)
);

`default_nettype wire
